// ----- hw/rtl/apbe_pkg.sv -----
// ----------------------------------------------------------------------------
// apbe_pkg: shared types and constants
// Widths, register indexes and the sequencer state type of the averaged
// pitch-bend encoder.
// ----------------------------------------------------------------------------
package apbe_pkg;

   localparam int WINDOW_DEPTH = 64;

   localparam int SAMPLE_W = 10;
   localparam int SHIFT_W  = 4;
   localparam int VALUE_W  = SAMPLE_W + SHIFT_W;
   localparam int HALF_W   = 7;
   localparam int CHAN_W   = 4;
   localparam int STRIDE_W = 5;
   localparam int LEN_W    = 7;

   localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W    = VALUE_W + SLOT_W;
   localparam int STEP_W   = $clog2(SUM_W + 1);

   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_BASE_CHANNEL = 2'd0;
   localparam logic [1:0] REG_BANK_OFFSET  = 2'd1;
   localparam logic [1:0] REG_STRIDE       = 2'd2;
   localparam logic [1:0] REG_AVG_LENGTH   = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0]   base_channel;
      logic [CHAN_W-1:0]   bank_offset;
      logic [STRIDE_W-1:0] channels_per_bank;
      logic [LEN_W-1:0]    average_length;
      logic                window_clear;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/apbe_csr.sv -----
// ----------------------------------------------------------------------------
// apbe_csr: configuration registers
// APB-style register file; a write of the averaging length pulses a
// window clear toward the datapath.
// ----------------------------------------------------------------------------
module apbe_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [apbe_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [apbe_pkg::DATA_W-1:0] csr_pwdata,
   output logic [apbe_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output apbe_pkg::cfg_type           cfg
);

   logic [apbe_pkg::CHAN_W-1:0]   base_ff, base_in;
   logic [apbe_pkg::CHAN_W-1:0]   bank_ff, bank_in;
   logic [apbe_pkg::STRIDE_W-1:0] stride_ff, stride_in;
   logic [apbe_pkg::LEN_W-1:0]    length_ff, length_in;
   logic                          clear_ff, clear_in;
   logic                          wr_en;
   logic [1:0]                    reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      base_in   = base_ff;
      bank_in   = bank_ff;
      stride_in = stride_ff;
      length_in = length_ff;
      clear_in  = 1'b0;
      if (wr_en) begin
         unique case (reg_index)
            apbe_pkg::REG_BASE_CHANNEL: base_in   = csr_pwdata[apbe_pkg::CHAN_W-1:0];
            apbe_pkg::REG_BANK_OFFSET:  bank_in   = csr_pwdata[apbe_pkg::CHAN_W-1:0];
            apbe_pkg::REG_STRIDE:       stride_in = csr_pwdata[apbe_pkg::STRIDE_W-1:0];
            apbe_pkg::REG_AVG_LENGTH: begin
               length_in = csr_pwdata[apbe_pkg::LEN_W-1:0];
               clear_in  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         apbe_pkg::REG_BASE_CHANNEL: csr_prdata = apbe_pkg::DATA_W'(base_ff);
         apbe_pkg::REG_BANK_OFFSET:  csr_prdata = apbe_pkg::DATA_W'(bank_ff);
         apbe_pkg::REG_STRIDE:       csr_prdata = apbe_pkg::DATA_W'(stride_ff);
         apbe_pkg::REG_AVG_LENGTH:   csr_prdata = apbe_pkg::DATA_W'(length_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         bank_ff   <= '0;
         stride_ff <= apbe_pkg::STRIDE_W'(1);
         length_ff <= '0;
         clear_ff  <= 1'b0;
      end else begin
         base_ff   <= base_in;
         bank_ff   <= bank_in;
         stride_ff <= stride_in;
         length_ff <= length_in;
         clear_ff  <= clear_in;
      end
   end

   assign cfg.base_channel      = base_ff;
   assign cfg.bank_offset       = bank_ff;
   assign cfg.channels_per_bank = stride_ff;
   assign cfg.average_length    = length_ff;
   assign cfg.window_clear      = clear_ff;

endmodule

// ----- hw/rtl/apbe_divider.sv -----
// ----------------------------------------------------------------------------
// apbe_divider: bit-serial restoring divider
// Divides the window sum by the fill count, one quotient bit per cycle
// through a single shared compare-and-subtract.
// ----------------------------------------------------------------------------
module apbe_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [apbe_pkg::SUM_W-1:0] dividend,
   input  logic [apbe_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [apbe_pkg::SUM_W-1:0] quotient
);

   logic [apbe_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [apbe_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [apbe_pkg::CNT_W-1:0]  div_ff, div_in;
   logic [apbe_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        run_ff, run_in;
   logic [apbe_pkg::CNT_W:0]    trial;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[apbe_pkg::SUM_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      run_in  = run_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = apbe_pkg::STEP_W'(apbe_pkg::SUM_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (step_ff != '0) begin
            // shift in next dividend bit, subtract when the divisor fits
            rem_in  = fits ? apbe_pkg::CNT_W'(trial - {1'b0, div_ff})
                           : apbe_pkg::CNT_W'(trial);
            quo_in  = {quo_ff[apbe_pkg::SUM_W-2:0], fits};
            step_in = step_ff - apbe_pkg::STEP_W'(1);
         end else begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = run_ff && (step_ff == '0);
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/averaged_pitch_bend_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// averaged_pitch_bend_encoder_unit: averaged pitch-bend encoder
// Moving average over a ring of recent samples with change detection.
// Steps: with averaging off, an accepted beat goes from idle to finish;
//   with averaging on it passes read, update and divide, where the
//   bit-serial divider yields one quotient bit per cycle, then finish.
// Throughput: a new sample is taken only in idle; not ready while busy or
//   while a changed result waits on a full output register.
// Reset: synchronous; window contents read as zero until written (fill count).
// ----------------------------------------------------------------------------
module averaged_pitch_bend_encoder_unit (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: [9:0] sample, [15:10] zero
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,
   // rsp_tdata: [3:0] midi_channel, [10:4] bend_low, [17:11] bend_high,
   // [23:18] zero
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [apbe_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [apbe_pkg::DATA_W-1:0] csr_pwdata,
   output logic [apbe_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int VW = apbe_pkg::VALUE_W;
   localparam int SW = apbe_pkg::SLOT_W;
   localparam int CW = apbe_pkg::CNT_W;
   localparam int UW = apbe_pkg::SUM_W;
   localparam int HW = apbe_pkg::HALF_W;
   localparam int PROD_W = apbe_pkg::CHAN_W + apbe_pkg::STRIDE_W;

   apbe_pkg::cfg_type   cfg;
   apbe_pkg::state_type state_ff, state_in;

   logic [VW-1:0] window_mem [apbe_pkg::WINDOW_DEPTH];
   logic [VW-1:0] rd_ff;

   logic [VW-1:0] value_ff, value_in;
   logic [VW-1:0] result_ff, result_in;
   logic [VW-1:0] last_ff, last_in;
   logic [UW-1:0] sum_ff, sum_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] addr_ff, addr_in;
   logic [CW-1:0] filled_ff, filled_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [apbe_pkg::CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic [VW-1:0]               rsp_value_ff, rsp_value_in;

   logic [CW-1:0]     eff_len;
   logic [CW-1:0]     slot_next;
   logic [VW-1:0]     old_value;
   logic              mem_we;
   logic              div_start;
   logic              div_done;
   logic [UW-1:0]     div_quotient;
   logic [PROD_W-1:0] chan_prod;
   logic [PROD_W-1:0] chan_sum;

   apbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   apbe_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (filled_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // saturate the window length to the ring depth
   assign eff_len = (32'(cfg.average_length) > 32'(apbe_pkg::WINDOW_DEPTH))
                  ? CW'(apbe_pkg::WINDOW_DEPTH) : CW'(cfg.average_length);

   assign slot_next = CW'(addr_ff) + CW'(1);
   // until the ring is full the slot being replaced was never written
   assign old_value = (filled_ff < eff_len) ? '0 : rd_ff;

   assign chan_prod = PROD_W'(cfg.bank_offset) * PROD_W'(cfg.channels_per_bank);
   assign chan_sum  = PROD_W'(cfg.base_channel) + chan_prod;

   assign req_tready = (state_ff == apbe_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      result_in    = result_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      slot_in      = slot_ff;
      addr_in      = addr_ff;
      filled_in    = filled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_value_in = rsp_value_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         apbe_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               value_in = {req_tdata[apbe_pkg::SAMPLE_W-1:0], {apbe_pkg::SHIFT_W{1'b0}}};
               // a pending window clear restarts the ring at slot zero
               addr_in  = (cfg.window_clear || CW'(slot_ff) >= eff_len) ? '0 : slot_ff;
               if (eff_len >= CW'(2)) begin
                  state_in = apbe_pkg::ST_READ;
               end else begin
                  result_in = value_in;
                  state_in  = apbe_pkg::ST_FINISH;
               end
            end
         end
         apbe_pkg::ST_READ: begin
            state_in = apbe_pkg::ST_UPDATE;
         end
         apbe_pkg::ST_UPDATE: begin
            sum_in    = sum_ff - UW'(old_value) + UW'(value_ff);
            mem_we    = 1'b1;
            slot_in   = (slot_next >= eff_len) ? '0 : SW'(slot_next);
            filled_in = (filled_ff < eff_len) ? filled_ff + CW'(1) : filled_ff;
            div_start = 1'b1;
            state_in  = apbe_pkg::ST_DIVIDE;
         end
         apbe_pkg::ST_DIVIDE: begin
            if (div_done) begin
               result_in = div_quotient[VW-1:0];
               state_in  = apbe_pkg::ST_FINISH;
            end
         end
         apbe_pkg::ST_FINISH: begin
            if (result_ff == last_ff) begin
               state_in = apbe_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               // load the output register, hold otherwise
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_sum[apbe_pkg::CHAN_W-1:0];
               rsp_value_in = result_ff;
               last_in      = result_ff;
               state_in     = apbe_pkg::ST_IDLE;
            end
         end
         default: state_in = apbe_pkg::ST_IDLE;
      endcase

      if (cfg.window_clear) begin
         sum_in    = '0;
         slot_in   = '0;
         filled_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         sum_ff       <= '0;
         slot_ff      <= '0;
         filled_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
      end
      value_ff     <= value_in;
      result_ff    <= result_in;
      addr_ff      <= addr_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == apbe_pkg::ST_READ) begin
         rd_ff <= window_mem[addr_ff];
      end
      if (mem_we) begin
         window_mem[addr_ff] <= value_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_value_ff[VW-1:HW], rsp_value_ff[HW-1:0], rsp_chan_ff};

endmodule

// ----- verif/pitch_bend_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_bend_checker: scoreboard for the averaged pitch-bend encoder
// Watches the sample, bend and register ports, predicts every bend beat from
// its own copy of the averaging window and the channel settings, and compares
// each returned beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pitch_bend_checker
   import apbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [15:0]       req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [23:0]       rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                outstanding
);

   typedef struct packed {
      logic [HALF_W-1:0] bend_high;
      logic [HALF_W-1:0] bend_low;
      logic [CHAN_W-1:0] channel;
   } bend_beat_t;

   bend_beat_t         bend_queue [$];

   logic [CHAN_W-1:0]   base_channel;
   logic [CHAN_W-1:0]   bank_offset;
   logic [STRIDE_W-1:0] bank_stride;
   logic [LEN_W-1:0]    avg_length;

   logic [VALUE_W-1:0]  ring [WINDOW_DEPTH];
   int                  ring_sum;
   int                  write_slot;
   int                  filled;
   logic [VALUE_W-1:0]  last_bend;

   task automatic clear_ring();
      for (int i = 0; i < WINDOW_DEPTH; i++)
         ring[i] = '0;
      ring_sum   = 0;
      write_slot = 0;
      filled     = 0;
   endtask

   task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      case (addr[ADDR_W-1:2])
         REG_BASE_CHANNEL: base_channel = data[CHAN_W-1:0];
         REG_BANK_OFFSET:  bank_offset  = data[CHAN_W-1:0];
         REG_STRIDE:       bank_stride  = data[STRIDE_W-1:0];
         REG_AVG_LENGTH: begin
            // any length write restarts the window, the last sent value stays
            avg_length = data[LEN_W-1:0];
            clear_ring();
         end
         default: ;
      endcase
   endtask

   task automatic predict_bend(input logic [SAMPLE_W-1:0] sample);
      logic [VALUE_W-1:0] bend;
      int                 span;
      int                 pos;
      int                 chan_sum;
      bend_beat_t         beat;
      bend = VALUE_W'(sample) << SHIFT_W;
      span = (avg_length > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(avg_length);
      if (span >= 2) begin
         pos = (write_slot >= span) ? 0 : write_slot;
         ring_sum  = ring_sum - int'(ring[pos]) + int'(bend);
         ring[pos] = bend;
         pos++;
         write_slot = (pos >= span) ? 0 : pos;
         if (filled < span)
            filled++;
         bend = VALUE_W'(ring_sum / filled);
      end
      if (bend != last_bend) begin
         last_bend      = bend;
         chan_sum       = int'(base_channel) + int'(bank_offset) * int'(bank_stride);
         beat.channel   = CHAN_W'(chan_sum);
         beat.bend_low  = bend[HALF_W-1:0];
         beat.bend_high = bend[VALUE_W-1:HALF_W];
         bend_queue.push_back(beat);
      end
   endtask

   task automatic check_beat(input logic [23:0] data);
      bend_beat_t got;
      bend_beat_t want;
      got.channel   = data[3:0];
      got.bend_low  = data[10:4];
      got.bend_high = data[17:11];
      if (bend_queue.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected bend beat: chan %0d low %0d high %0d",
                     got.channel, got.bend_low, got.bend_high);
      end else begin
         want = bend_queue.pop_front();
         if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"bend beat: expected chan %0d low %0d high %0d,",
                         " got chan %0d low %0d high %0d"},
                        want.channel, want.bend_low, want.bend_high,
                        got.channel, got.bend_low, got.bend_high);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_channel = '0;
         bank_offset  = '0;
         bank_stride  = STRIDE_W'(1);
         avg_length   = '0;
         last_bend    = '0;
         clear_ring();
         bend_queue.delete();
         fail_count   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_beat(rsp_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_write(csr_paddr, csr_pwdata);
         if (req_tvalid && req_tready)
            predict_bend(req_tdata[SAMPLE_W-1:0]);
      end
      outstanding <= bend_queue.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: averaged pitch-bend encoder testbench
// Streams converter samples through a series of channel and window settings,
// with bursty input, a stalling result side and one long result hold-off.
// The checker predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import apbe_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE       = SUM_W + 16;
   localparam int PHASE_ITEMS  = 75;
   localparam int PHASE_COUNT  = 9;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AT_BEAT = 150;

   typedef struct {
      int base;
      int bank;
      int stride;
      int span;
   } setting_t;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [23:0]       rsp_tdata;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   int fail_count;
   int outstanding;
   int idle_cycles;
   int burst_left;

   setting_t plan [PHASE_COUNT];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   averaged_pitch_bend_encoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pitch_bend_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Result side: random stall modes, plus one long hold-off mid-run.
   int  stall_mode;
   int  mode_left;
   int  hold_left;
   int  beats_seen;
   bit  hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode = 0;
         mode_left  = 0;
         hold_left  = 0;
         beats_seen = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            beats_seen++;
         // start the hold-off while the sender is offering samples
         if (!hold_done && beats_seen >= HOLD_AT_BEAT && req_tvalid) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // End the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("averaged_pitch_bend_encoder_unit: mismatch");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= 16'(sample);
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every bend beat is back and the block is idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      // the pending count is a registered copy of the prediction queue size
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({index, 2'b00});
      csr_pwdata  <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic apply_setting(input setting_t s);
      csr_write(REG_BASE_CHANNEL, s.base);
      csr_write(REG_BANK_OFFSET, s.bank);
      csr_write(REG_STRIDE, s.stride);
      csr_write(REG_AVG_LENGTH, s.span);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] prev);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return SAMPLE_W'($urandom_range(0, 1023));
      else if (pick < 70)
         return prev;
      else if (pick < 80)
         return ($urandom_range(0, 1) != 0) ? '1 : '0;
      else
         return prev + SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
   endfunction

   logic [SAMPLE_W-1:0] opening [14] = '{
      10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'h000, 10'h2AA, 10'h155,
      10'h001, 10'h200, 10'h3FE, 10'h3FE, 10'h07F, 10'h080, 10'h000
   };

   initial begin
      logic [SAMPLE_W-1:0] sample;
      burst_left = 0;
      sample     = '0;
      // channel extremes, wrap past 15, saturating and disabled windows,
      // and a rewrite of the same length to restart the window
      plan[0] = '{15, 15, 16, 64};
      plan[1] = '{15, 1, 1, 2};
      plan[2] = '{3, 5, 7, 127};
      plan[3] = '{0, 0, 0, 1};
      plan[4] = '{$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 16), 100};
      plan[5] = '{$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 16), 4};
      plan[6] = '{plan[5].base, plan[5].bank, plan[5].stride, 4};
      plan[7] = '{9, 6, 11, 3};
      plan[8] = '{$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 16),
                  $urandom_range(0, 64)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: averaging off, channel zero
      foreach (opening[i])
         send_sample(opening[i]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         apply_setting(plan[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sample = next_sample(sample);
            send_sample(sample);
         end
      end

      drain();
      if (fail_count == 0)
         $display("averaged_pitch_bend_encoder_unit: match");
      else
         $display("averaged_pitch_bend_encoder_unit: mismatch");
      $finish;
   end

endmodule
